// ===== rtl/log_spaced_table_interpolator_macros.svh =====
// Assertion macros for the log-spaced table interpolator.
// Included by files that check their own logic; no other dependencies.
`ifndef LOG_SPACED_TABLE_INTERPOLATOR_MACROS_SVH
`define LOG_SPACED_TABLE_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define LSTI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent
`define LSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LSTI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lsti_pkg.sv =====
// Shared types and constants of the log-spaced table interpolator.
// No dependencies.
package lsti_pkg;

  // ln 2 in unsigned Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam int unsigned LOG_FRAC = 24;
  // normalise stage plus one squaring stage per fraction bit
  localparam int unsigned LOG_LAT = LOG_FRAC + 1;
  localparam int unsigned IDX_LAT = 3;

  localparam logic [31:0] THRESHOLD_RESET = 32'd983040;
  localparam logic [23:0] SCALE_RESET = 24'd2504786;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SCALE     = 2'd1
  } lsti_reg_e;

  // sideband carried beside the arithmetic
  typedef struct packed {
    logic        kind;
    logic [6:0]  idx;
    logic [23:0] value;
    logic        ezero;
    logic        tzero;
  } lsti_side_t;

  typedef struct packed {
    logic zero;
    logic last;
  } lsti_flag_t;

endpackage

// ===== rtl/lsti_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module lsti_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read, held while stalled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== rtl/lsti_log2.sv =====
// Pipelined base-2 logarithm of a 32-bit word, Q.24 result, by repeated squaring.
// Depends on lsti_pkg.
module lsti_log2 import lsti_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [28:0] log_o
);

  logic [4:0]  p_d;
  logic [4:0]  p_q [LOG_LAT];
  logic [31:0] m_q [LOG_LAT];
  logic [23:0] f_q [LOG_LAT];

  // find the top set bit
  always_comb begin
    p_d = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) begin
        p_d = 5'(i);
      end
    end
  end

  // normalise the mantissa to Q1.31
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= p_d;
      m_q[0] <= x_i << (5'd31 - p_d);
      f_q[0] <= '0;
    end
  end

  // one fraction bit per squaring stage
  for (genvar k = 1; k < LOG_LAT; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'd0, m_q[k-1]} * {32'd0, m_q[k-1]};
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k] <= p_q[k-1];
        m_q[k] <= t[32] ? t[32:1] : t[31:0];
        f_q[k] <= {f_q[k-1][22:0], t[32]};
      end
    end
  end

  assign log_o = {p_q[LOG_LAT-1], f_q[LOG_LAT-1]};

endmodule

// ===== rtl/lsti_index.sv =====
// Table position from two logarithms: ln ratio times scale, three stages.
// Depends on lsti_pkg.
module lsti_index import lsti_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [28:0] log_e_i,
  input  logic [28:0] log_t_i,
  input  logic        ezero_i,
  input  logic        tzero_i,
  input  logic [23:0] scale_i,
  output logic [28:0] s_o,
  output lsti_flag_t  flag_o
);

  logic signed [29:0] d;
  logic [28:0] d_q;
  logic [28:0] u_q;
  logic [28:0] s_q;
  logic [60:0] pu;
  logic [52:0] ps;
  lsti_flag_t  f1_q, f2_q, f3_q;

  assign d  = $signed({1'b0, log_e_i}) - $signed({1'b0, log_t_i});
  assign pu = 61'(d_q) * 61'(LN2_Q32);
  assign ps = 53'(u_q) * 53'(scale_i);

  // difference, sign handling, two products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q       <= d[29] ? '0 : d[28:0];
      f1_q.zero <= ezero_i | (!tzero_i & d[29] & (scale_i != '0));
      f1_q.last <= !ezero_i & tzero_i;
      u_q       <= pu[60:32];
      f2_q      <= f1_q;
      s_q       <= ps[52:24];
      f3_q      <= f2_q;
    end
  end

  assign s_o    = s_q;
  assign flag_o = f3_q;

endmodule

// ===== rtl/lsti_interp.sv =====
// Linear interpolation between two table words, clamped to a non-negative result.
// Depends on lsti_pkg.
module lsti_interp import lsti_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] t0_i,
  input  logic [23:0] t1_i,
  input  logic [15:0] frac_i,
  input  logic        zero_i,
  output logic [22:0] result_o
);

  logic signed [24:0] diff;
  logic signed [41:0] prod;
  logic signed [41:0] prod_q;
  logic signed [23:0] t0_q;
  logic               zero_q;
  logic signed [25:0] q;
  logic signed [26:0] r;

  assign diff = $signed({t1_i[23], t1_i}) - $signed({t0_i[23], t0_i});
  assign prod = 42'(diff) * $signed({26'd0, frac_i});

  // hold the product for the next stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
      t0_q   <= $signed(t0_i);
      zero_q <= zero_i;
    end
  end

  // floor divide by 65536, add the base word, clamp
  assign q = 26'(prod_q >>> 16);
  assign r = 27'(t0_q) + 27'(q);
  assign result_o = (zero_q || r[26] || r == '0) ? '0 : r[22:0];

endmodule

// ===== rtl/log_spaced_table_interpolator.sv =====
// Log-spaced table interpolator: loads table words and answers energy queries.
// Throughput: one item per cycle; the whole pipeline halts while a result waits.
// Reset clears all valid bits and sets the threshold and scale to their defaults;
// the table stays undefined until loaded. Depends on lsti_pkg and the submodules.
`include "log_spaced_table_interpolator_macros.svh"
module log_spaced_table_interpolator import lsti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] entry_index, [30:7] entry_value, [62:31] energy, [63] zero
  input  logic [63:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [22:0] cross_section, [23] zero
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned NSTG = LOG_LAT + IDX_LAT + 2;
  localparam int unsigned IDXS = LOG_LAT + IDX_LAT - 1;
  localparam logic [12:0] LAST_POS = 13'(TABLE_DEPTH - 1);

  logic [31:0] thr_q;
  logic [23:0] scale_q;
  logic        adv;
  logic        vld_q  [NSTG];
  lsti_side_t  side_q [NSTG];
  lsti_side_t  side_in;
  logic [28:0] log_e, log_t, s;
  lsti_flag_t  flag;
  logic [12:0] pos;
  logic        last;
  logic [AW-1:0] ra, rb;
  logic [23:0] t0, t1;
  logic [15:0] frac_q;
  logic        zero_q;
  logic        we;
  logic [22:0] result;
  logic        out_vld_q;
  logic [22:0] out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_THRESHOLD: thr_q   <= cfg_data_i;
        REG_SCALE:     scale_q <= cfg_data_i[23:0];
        default:       ;
      endcase
    end
  end

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign side_in.kind  = s_axis_tuser;
  assign side_in.idx   = s_axis_tdata[6:0];
  assign side_in.value = s_axis_tdata[30:7];
  assign side_in.ezero = s_axis_tdata[62:31] == '0;
  assign side_in.tzero = thr_q == '0;

  // advance valid bits and sideband with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < NSTG; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  lsti_log2 u_log_e (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (s_axis_tdata[62:31]),
    .log_o (log_e)
  );

  lsti_log2 u_log_t (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (thr_q),
    .log_o (log_t)
  );

  lsti_index u_index (
    .clk_i   (clk_i),
    .en_i    (adv),
    .log_e_i (log_e),
    .log_t_i (log_t),
    .ezero_i (side_q[LOG_LAT-1].ezero),
    .tzero_i (side_q[LOG_LAT-1].tzero),
    .scale_i (scale_q),
    .s_o     (s),
    .flag_o  (flag)
  );

  // table addresses; past the end read the last word with no fraction
  assign pos  = s[28:16];
  assign last = flag.last || pos >= LAST_POS;
  assign ra   = last ? AW'(TABLE_DEPTH - 1) : pos[AW-1:0];
  assign rb   = last ? AW'(TABLE_DEPTH - 1) : AW'(pos + 13'd1);

  // loads write when they reach the read stage, keeping item order
  assign we = adv && vld_q[IDXS] && !side_q[IDXS].kind &&
              (11'(side_q[IDXS].idx) < 11'(TABLE_DEPTH));

  lsti_ram #(
    .WIDTH (24),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .en_i      (adv),
    .we_i      (we),
    .waddr_i   (AW'(side_q[IDXS].idx)),
    .wdata_i   (side_q[IDXS].value),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (t0),
    .rdata_b_o (t1)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frac_q <= last ? '0 : s[15:0];
      zero_q <= flag.zero;
    end
  end

  lsti_interp u_interp (
    .clk_i    (clk_i),
    .en_i     (adv),
    .t0_i     (t0),
    .t1_i     (t1),
    .frac_i   (frac_q),
    .zero_i   (zero_q),
    .result_o (result)
  );

  // output register; loads leave no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NSTG-1] && side_q[NSTG-1].kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};

  `LSTI_ASSERT_SAME(a_stall_back, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `LSTI_ASSERT_NEXT(a_load_no_out, clk_i, rst_ni, adv && !(vld_q[NSTG-1] && side_q[NSTG-1].kind), !m_axis_tvalid)
  `LSTI_ASSERT_SAME(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid), $past(vld_q[NSTG-1]))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the log-spaced table interpolator.
// Predicts each cross-section in fixed point and compares the results in order.
// Depends on lsti_pkg and log_spaced_table_interpolator.
module testbench;
  import lsti_pkg::*;

  localparam int unsigned DEPTH = 100;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [1:0] REG_UNUSED = 2'd2;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [6:0] entry_index, [30:7] entry_value, [62:31] energy, [63] zero
  logic [63:0] s_axis_tdata = '0;
  // [0] kind
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [22:0] cross_section, [23] zero
  logic [23:0] m_axis_tdata;

  // predictor state
  logic [31:0] model_threshold;
  logic [23:0] model_scale;
  int          model_table [DEPTH];
  logic [22:0] sigma_expected [$];

  int fail_count = 0;
  int mismatch_count = 0;
  int long_stall_len = 0;

  log_spaced_table_interpolator #(.TABLE_DEPTH(DEPTH)) u_top (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint log2_q24(logic [31:0] x);
    int p;
    longint unsigned m;
    longint frac;
    p = 31;
    frac = 0;
    while (p > 0 && !x[p]) p--;
    m = {32'b0, x} << (31 - p);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(p) << 24) + frac;
  endfunction

  function automatic logic [22:0] clamp_sigma(longint q);
    if (q <= 0) return '0;
    return q[22:0];
  endfunction

  function automatic logic [22:0] predict_sigma(logic [31:0] energy);
    longint d, diff, q;
    longint unsigned u, s, l, f;
    if (energy == 0) return '0;
    if (model_threshold == 0) return clamp_sigma(model_table[DEPTH-1]);
    d = log2_q24(energy) - log2_q24(model_threshold);
    if (d < 0) begin
      if (model_scale != 0) return '0;
      d = 0;
    end
    u = (longint'(d) * {32'b0, LN2_Q32}) >> 32;
    s = (u * {40'b0, model_scale}) >> 24;
    l = s >> 16;
    f = s & 64'hFFFF;
    if (l >= DEPTH - 1) return clamp_sigma(model_table[DEPTH-1]);
    diff = longint'(model_table[l+1]) - longint'(model_table[l]);
    q = (diff * longint'(f)) >>> 16;
    return clamp_sigma(longint'(model_table[l]) + q);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic kind, logic [6:0] idx, logic [23:0] value,
                           logic [31:0] energy);
    int gap;
    logic rdy;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, energy, value, idx};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    // item taken at this edge: update the predictor
    if (kind == KIND_LOAD) begin
      if (idx < DEPTH) model_table[idx] = int'($signed(value));
    end else begin
      sigma_expected.push_back(predict_sigma(energy));
    end
  endtask

  task automatic load_entry(int idx, int value);
    send_item(KIND_LOAD, 7'(idx), 24'(value), $urandom);
  endtask

  task automatic query(logic [31:0] energy);
    send_item(KIND_QUERY, 7'($urandom), 24'($urandom), energy);
  endtask

  // Drain the pipeline so that a register can be written while idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sigma_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == REG_THRESHOLD) model_threshold = data;
    else if (addr == REG_SCALE) model_scale = data[23:0];
  endtask

  // Fill the whole table so no query reads an unwritten entry
  task automatic test_table_load();
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 7) load_entry(i, -8388608);
      else if (i == 8 || i == DEPTH - 1) load_entry(i, 8388607);
      else if ($urandom_range(0, 5) == 0) load_entry(i, -$urandom_range(0, 200000));
      else load_entry(i, $urandom_range(0, 8388607));
    end
    // out-of-range positions are dropped
    load_entry(DEPTH, 12345);
    load_entry(127, -1);
  endtask

  task automatic test_directed_queries();
    query(32'd0);
    query(32'hFFFF_FFFF);
    query(model_threshold);
    query(model_threshold - 1);
    query(32'd1);
    query(32'h0001_0000);
    query(model_threshold + 32'h0000_8000);
    // energies landing on entries inside the table
    query(32'h0020_0000);
    query(32'h0028_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    query(32'h0030_0000);
    // zero threshold: unbounded ratio selects the last entry for a nonzero energy
    write_reg(REG_THRESHOLD, 32'd0);
    query(32'd5);
    query(32'd0);
    // zero scale: every nonzero energy selects entry 0
    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
    write_reg(REG_SCALE, 24'd0);
    query(32'd3);
    query(32'hFFFF_FFFF);
    write_reg(REG_SCALE, SCALE_RESET);
  endtask

  task automatic random_phase(int n_items);
    logic [31:0] e;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(KIND_LOAD, 7'($urandom_range(0, 127)), 24'($urandom), $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: e = model_threshold + $urandom_range(0, 65535);
          1: e = $urandom;
          default: e = $urandom >> $urandom_range(0, 31);
        endcase
        query(e);
      end
    end
  endtask

  task automatic test_random();
    logic [31:0] thr [6];
    logic [23:0] scl [6];
    thr = '{THRESHOLD_RESET, 32'h0001_0000, 32'hFFFF_FFFF, $urandom, 32'h0001_0000, $urandom};
    scl = '{SCALE_RESET, 24'hFF_FFFF, 24'd1, 24'($urandom), 24'($urandom_range(1, 2000000)),
            24'd65536};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_THRESHOLD, thr[p]);
      write_reg(REG_SCALE, scl[p]);
      random_phase(95);
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  task automatic test_back_pressure();
    long_stall_len = 300;
    random_phase(60);
  endtask

  // Receiver: random stalls, a long hold-off on request
  initial begin : ready_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_stall_len > 0) begin
        stall_left = long_stall_len;
        long_stall_len = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
      end
    end
  end

  // Compare each result with the oldest expectation
  initial begin : result_check
    logic [22:0] want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (sigma_expected.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: cross_section=%0d", m_axis_tdata[22:0]);
        end else begin
          want = sigma_expected.pop_front();
          if (m_axis_tdata[22:0] !== want) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("cross_section mismatch: expected %0d, actual %0d",
                       want, m_axis_tdata[22:0]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #(12 * 1000000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : main
    model_threshold = THRESHOLD_RESET;
    model_scale = SCALE_RESET;
    foreach (model_table[i]) model_table[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_directed_queries();
    test_back_pressure();
    test_random();
    wait_idle();
    if (fail_count == 0 && sigma_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lsti_pkg.sv
rtl/lsti_ram.sv
rtl/lsti_log2.sv
rtl/lsti_index.sv
rtl/lsti_interp.sv
rtl/log_spaced_table_interpolator.sv
tb/testbench.sv
